[src/xmodem_crc_frame_receiver_assert.svh]
// Assertion macros shared by the receiver's checker.
`ifndef XMODEM_CRC_FRAME_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication under the clock with reset held off.
`define XCRC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xcrc assertion failed");

// Next-cycle implication under the clock with reset held off.
`define XCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xcrc assertion failed");

`endif

[src/xcrc_pkg.sv]
// Shared types, constants and the CRC-16/XMODEM byte update for the receiver.
`default_nettype none
package xcrc_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int IMAGE_BYTES   = 262144;
    localparam int FRAME_BYTES   = 3 + PAYLOAD_BYTES + 2;
    localparam int PAY_FIRST     = 3;
    localparam int CRC_HIGH_POS  = 3 + PAYLOAD_BYTES;

    localparam logic [7:0]  BYTE_EOT = 8'h04;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_ACK     = 3'd2,
        KIND_NAK     = 3'd3,
        KIND_CAN     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [17:0] image_offset;
        logic        transfer_done;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[src/xcrc_frame_ctrl.sv]
// Frame state, CRC accumulation and the per-word result decision.
`default_nettype none
module xcrc_frame_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             frame_end,
    output xcrc_pkg::result_t     result
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  pos_reg, pos_next;
    logic [18:0] acc_reg, acc_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  crch_reg, crch_next;
    logic        fin_reg, fin_next;

    logic        image_full;
    logic        in_payload;
    logic [15:0] crc_got;
    logic [6:0]  pay_index;

    assign image_full = ({1'b0, acc_reg} + 20'(xcrc_pkg::PAYLOAD_BYTES))
                        > 20'(xcrc_pkg::IMAGE_BYTES);
    assign in_payload = (pos_reg >= 8'(xcrc_pkg::PAY_FIRST))
                        && (pos_reg < 8'(xcrc_pkg::CRC_HIGH_POS));
    assign pay_index  = 7'(pos_reg - 8'(xcrc_pkg::PAY_FIRST));

    always_comb begin
        crc_next   = crc_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        first_next = (pos_reg == 8'd0) ? rx_byte : first_reg;
        crch_next  = (pos_reg == 8'(xcrc_pkg::CRC_HIGH_POS)) ? rx_byte : crch_reg;
        fin_next   = fin_reg;
        crc_got    = {crch_next, rx_byte};

        result.kind          = xcrc_pkg::KIND_NONE;
        result.payload_byte  = 8'd0;
        result.image_offset  = 18'd0;

        if (fin_reg) begin
            first_next = first_reg;
            crch_next  = crch_reg;
        end else if (frame_end) begin
            if (pos_reg == 8'd0) begin
                if (first_next == xcrc_pkg::BYTE_EOT) begin
                    result.kind = xcrc_pkg::KIND_ACK;
                    fin_next    = 1'b1;
                end else begin
                    result.kind = xcrc_pkg::KIND_NAK;
                end
            end else if (pos_reg == 8'(xcrc_pkg::FRAME_BYTES - 1)) begin
                if (image_full) begin
                    result.kind = xcrc_pkg::KIND_CAN;
                end else if (crc_got == crc_reg) begin
                    result.kind = xcrc_pkg::KIND_ACK;
                    acc_next    = acc_reg + 19'(xcrc_pkg::PAYLOAD_BYTES);
                end else begin
                    result.kind = xcrc_pkg::KIND_NAK;
                end
            end else begin
                result.kind = xcrc_pkg::KIND_NAK;
            end
            pos_next = 8'd0;
            crc_next = 16'd0;
        end else begin
            if (in_payload) begin
                crc_next = xcrc_pkg::crc_byte(crc_reg, rx_byte);
                if (!image_full) begin
                    result.kind         = xcrc_pkg::KIND_PAYLOAD;
                    result.payload_byte = rx_byte;
                    result.image_offset = acc_reg[17:0] + {11'd0, pay_index};
                end
            end
            if (pos_reg != 8'hFF) begin
                pos_next = pos_reg + 8'd1;
            end
        end
        result.transfer_done = fin_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= 16'd0;
            pos_reg   <= 8'd0;
            acc_reg   <= 19'd0;
            first_reg <= 8'd0;
            crch_reg  <= 8'd0;
            fin_reg   <= 1'b0;
        end else if (step) begin
            crc_reg   <= crc_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            first_reg <= first_next;
            crch_reg  <= crch_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
`default_nettype wire

[src/xmodem_crc_frame_receiver.sv]
// A word accepted into the input register has its result word registered into the m_ side register.
// Throughput: one word per cycle while m_ready does not stall; a stalled result holds the input word.
// Each input word gives exactly one result word.
// Reset is synchronous and active low; it clears the frame state, the image
// offset, the transfer-done flag and the valid flags of both register stages.
`default_nettype none
module xmodem_crc_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_frame_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_result_kind,
    output logic [7:0]       m_payload_byte,
    output logic [17:0]      m_image_offset,
    output logic             m_transfer_done
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    logic              out_valid_reg;
    xcrc_pkg::result_t out_reg;
    xcrc_pkg::result_t res;
    logic              advance;
    logic              step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    xcrc_frame_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .frame_end (in_end_reg),
        .result    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
            in_end_reg  <= s_frame_end;
        end
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = 3'(out_reg.kind);
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_image_offset  = out_reg.image_offset;
    assign m_transfer_done = out_reg.transfer_done;

endmodule
`default_nettype wire

[src/xcrc_checker.sv]
// Port-level checker for the receiver and its bind to the top level.
`default_nettype none
`include "xmodem_crc_frame_receiver_assert.svh"
module xcrc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_result_kind,
    input wire logic [7:0]  m_payload_byte,
    input wire logic [17:0] m_image_offset,
    input wire logic        m_transfer_done
);

    `XCRC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_kind) && $stable(m_image_offset))
    `XCRC_ASSERT_NEXT(a_done_sticks, aclk, aresetn, m_valid && m_ready && m_transfer_done, !m_valid || m_transfer_done)
    `XCRC_ASSERT_NOW(a_done_kind, aclk, aresetn, m_valid && m_transfer_done, m_result_kind == 3'(xcrc_pkg::KIND_NONE) || m_result_kind == 3'(xcrc_pkg::KIND_ACK))
    `XCRC_ASSERT_NOW(a_payload_only, aclk, aresetn, m_valid && m_result_kind != 3'(xcrc_pkg::KIND_PAYLOAD), m_payload_byte == 8'd0 && m_image_offset == 18'd0)

endmodule

bind xmodem_crc_frame_receiver xcrc_checker u_xcrc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_kind   (m_result_kind),
    .m_payload_byte  (m_payload_byte),
    .m_image_offset  (m_image_offset),
    .m_transfer_done (m_transfer_done)
);
`default_nettype wire
